@@ rtl/core/apq_pkg.sv @@
package apq_pkg;

  // Default number of entries the queue holds
  localparam int unsigned CAPACITY_DEF = 64;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_EXTRACT  = 3'd1,
    OP_PEEK     = 3'd2,
    OP_MODIFY   = 3'd3,
    OP_INCREASE = 3'd4,
    OP_DECREASE = 3'd5
  } apq_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } apq_status_e;

  // Input transaction
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } apq_in_t;

  // Output transaction
  typedef struct packed {
    logic signed [31:0] result_value;
    apq_status_e        status;
    logic [6:0]         entry_count;
  } apq_out_t;

  // One stored queue entry
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } apq_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic        latch_req;
    logic        insert_write;
    logic        scan_start;
    logic        scan_step;
    logic        key_write;
    logic        comp_start;
    logic        comp_step;
    logic        count_dec;
    logic        set_status;
    apq_status_e status_code;
    logic        load_out;
  } apq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       full;
    logic       scan_last;
    logic       match;
    logic       best_is_last;
    logic       comp_last;
  } apq_stat_t;

endpackage

@@ rtl/core/array_priority_queue.sv @@
// Insert, unused codes and empty or full cases finish without a scan; peek scans
// all held entries, a key change scans up to the first match, and extract scans
// all entries, then moves the ones after the removed entry down. One transaction is
// in flight at a time; no input is taken until the response is loaded for output.
// Scan and compaction move one entry per cycle via the single read and write port.
// Reset clears the entry count, controller and output valid; memory is not cleared.
module array_priority_queue import apq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  apq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output apq_out_t out_data_o
);

  apq_cmd_t  cmd;
  apq_stat_t stat;

  apq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  apq_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_data_o(out_data_o)
  );

endmodule

@@ rtl/core/apq_ram.sv @@
module apq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/apq_datapath.sv @@
module apq_datapath import apq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  apq_in_t   in_data_i,
  input  apq_cmd_t  cmd_i,
  output apq_stat_t stat_o,
  output apq_out_t  out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  apq_in_t            req_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      ia_q;
  logic [AW-1:0]      di_q;
  logic [AW-1:0]      wp_q;
  logic [AW-1:0]      best_pos_q;
  logic signed [31:0] best_pri_q;
  logic signed [31:0] best_val_q;
  logic signed [31:0] res_q;
  apq_status_e        status_q;
  apq_out_t           out_q;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  apq_entry_t         ram_wdata;
  logic [AW-1:0]      ram_raddr;
  apq_entry_t         rd;
  logic               take;
  logic               is_max;
  logic signed [31:0] new_pri;
  logic [CW+6:0]      cnt_wide;

  apq_ram #(
    .WIDTH($bits(apq_entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rd)
  );

  // Decode scan comparisons on the entry read back this cycle
  assign is_max = (req_q.op == OP_EXTRACT) || (req_q.op == OP_PEEK);
  assign take   = (di_q == '0) || ($signed(rd.prio) > best_pri_q);

  // New priority for a key change
  always_comb begin
    priority if (req_q.op == OP_INCREASE) begin
      new_pri = ($signed(req_q.item_priority) > $signed(rd.prio)) ? req_q.item_priority
                                                                    : rd.prio;
    end else if (req_q.op == OP_DECREASE) begin
      new_pri = ($signed(req_q.item_priority) < $signed(rd.prio)) ? req_q.item_priority
                                                                    : rd.prio;
    end else begin
      new_pri = req_q.item_priority;
    end
  end

  // Select the memory read address
  always_comb begin
    priority if (cmd_i.scan_start) begin
      ram_raddr = '0;
    end else if (cmd_i.comp_start) begin
      ram_raddr = AW'(best_pos_q + AW'(1));
    end else if (cmd_i.comp_step) begin
      ram_raddr = AW'(wp_q + AW'(2));
    end else begin
      ram_raddr = ia_q[AW-1:0];
    end
  end

  // Select the memory write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = '{value: req_q.item_value, prio: req_q.item_priority};
    priority if (cmd_i.insert_write) begin
      ram_we = 1'b1;
    end else if (cmd_i.key_write) begin
      ram_we    = 1'b1;
      ram_waddr = di_q;
      ram_wdata = '{value: rd.value, prio: new_pri};
    end else if (cmd_i.comp_step) begin
      ram_we    = 1'b1;
      ram_waddr = wp_q;
      ram_wdata = rd;
    end
  end

  // Track the number of held entries
  always_comb begin
    count_d = count_q;
    if (cmd_i.insert_write) begin
      count_d = CW'(count_q + CW'(1));
    end else if (cmd_i.count_dec) begin
      count_d = CW'(count_q - CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Hold the request, scan pointers, running maximum and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_q    <= in_data_i;
      res_q    <= '0;
      status_q <= ST_OK;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status_code;
    end
    if (cmd_i.scan_start) begin
      ia_q <= CW'(1);
      di_q <= '0;
    end
    if (cmd_i.scan_step) begin
      ia_q <= CW'(ia_q + CW'(1));
      di_q <= AW'(di_q + AW'(1));
      if (is_max && take) begin
        best_pri_q <= rd.prio;
        best_val_q <= rd.value;
        best_pos_q <= di_q;
      end
      if (is_max && stat_o.scan_last) begin
        res_q <= take ? rd.value : best_val_q;
      end
    end
    if (cmd_i.comp_start) begin
      wp_q <= best_pos_q;
    end
    if (cmd_i.comp_step) begin
      wp_q <= AW'(wp_q + AW'(1));
    end
    if (cmd_i.load_out) begin
      out_q <= '{result_value: res_q, status: status_q, entry_count: cnt_wide[6:0]};
    end
  end

  assign cnt_wide = {7'b0, count_q};

  // Report status to the controller
  assign stat_o.op           = req_q.op;
  assign stat_o.empty        = (count_q == '0);
  assign stat_o.full         = (count_q >= CW'(CAPACITY));
  assign stat_o.scan_last    = (CW'(di_q) == CW'(count_q - CW'(1)));
  assign stat_o.match        = (rd.value == req_q.item_value);
  assign stat_o.best_is_last = (CW'(best_pos_q) == CW'(count_q - CW'(1)));
  assign stat_o.comp_last    = (CW'(wp_q) == CW'(count_q - CW'(2)));

  assign out_data_o = out_q;

endmodule

@@ rtl/core/apq_ctrl.sv @@
module apq_ctrl import apq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  apq_stat_t stat_i,
  output apq_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_CPREP,
    S_COMPACT,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   is_key;

  assign is_key = (stat_i.op == OP_MODIFY) || (stat_i.op == OP_INCREASE) ||
                  (stat_i.op == OP_DECREASE);

  // Sequence one transaction through the datapath
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FINISH;
        unique case (stat_i.op)
          OP_INSERT: begin
            if (stat_i.full) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = ST_FULL;
            end else begin
              cmd_o.insert_write = 1'b1;
            end
          end
          OP_EXTRACT, OP_PEEK: begin
            if (stat_i.empty) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = ST_EMPTY;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          OP_MODIFY, OP_INCREASE, OP_DECREASE: begin
            if (stat_i.empty) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = ST_NOT_FOUND;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (is_key) begin
          if (stat_i.match) begin
            cmd_o.key_write = 1'b1;
            state_d         = S_FINISH;
          end else if (stat_i.scan_last) begin
            cmd_o.set_status  = 1'b1;
            cmd_o.status_code = ST_NOT_FOUND;
            state_d           = S_FINISH;
          end
        end else if (stat_i.scan_last) begin
          state_d = (stat_i.op == OP_EXTRACT) ? S_CPREP : S_FINISH;
        end
      end
      S_CPREP: begin
        if (stat_i.best_is_last) begin
          cmd_o.count_dec = 1'b1;
          state_d         = S_FINISH;
        end else begin
          cmd_o.comp_start = 1'b1;
          state_d          = S_COMPACT;
        end
      end
      S_COMPACT: begin
        cmd_o.comp_step = 1'b1;
        if (stat_i.comp_last) begin
          cmd_o.count_dec = 1'b1;
          state_d         = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Set valid on load, drop it once the transaction is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ test/tb_array_priority_queue.sv @@
module tb_array_priority_queue;
  import apq_pkg::*;

  localparam int unsigned DEPTH = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 40;
  localparam int TIMEOUT_TIME = 8_000_000;

  // Op codes the block leaves without effect
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam logic signed [31:0] MIN_WORD = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_WORD = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_e;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  apq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  apq_out_t out_data;

  apq_in_t  pending_ops[$];
  apq_out_t expected_results[$];

  // Shadow copy of the queue contents
  logic signed [31:0] shadow_value[DEPTH];
  logic signed [31:0] shadow_prio[DEPTH];
  int                 shadow_count = 0;

  int       total_items = 0;
  int       accepted_count = 0;
  int       results_seen = 0;
  int       fail_count = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_e rx_mode = RX_STEADY;
  apq_out_t want;

  array_priority_queue DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Apply one operation to the shadow queue and return the expected response
  function automatic apq_out_t apply_queue_op(apq_in_t t);
    apq_out_t r;
    int best;
    int pos;
    r.result_value = '0;
    r.status = ST_OK;
    case (t.op)
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_value[shadow_count] = t.item_value;
          shadow_prio[shadow_count] = t.item_priority;
          shadow_count++;
        end
      end
      OP_EXTRACT, OP_PEEK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // earliest position wins a tie
          best = 0;
          for (int i = 1; i < shadow_count; i++) begin
            if (shadow_prio[i] > shadow_prio[best]) best = i;
          end
          r.result_value = shadow_value[best];
          if (t.op == OP_EXTRACT) begin
            for (int i = best; i + 1 < shadow_count; i++) begin
              shadow_value[i] = shadow_value[i + 1];
              shadow_prio[i] = shadow_prio[i + 1];
            end
            shadow_count--;
          end
        end
      end
      OP_MODIFY, OP_INCREASE, OP_DECREASE: begin
        // scan downward so the lowest matching position is kept
        pos = shadow_count;
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_value[i] == t.item_value) pos = i;
        end
        if (pos >= shadow_count) begin
          r.status = ST_NOT_FOUND;
        end else if (t.op == OP_MODIFY) begin
          shadow_prio[pos] = t.item_priority;
        end else if (t.op == OP_INCREASE) begin
          if (t.item_priority > shadow_prio[pos]) shadow_prio[pos] = t.item_priority;
        end else begin
          if (t.item_priority < shadow_prio[pos]) shadow_prio[pos] = t.item_priority;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = 7'(shadow_count);
    return r;
  endfunction

  task automatic add_item(logic [2:0] op, logic signed [31:0] v, logic signed [31:0] p);
    apq_in_t t;
    t.op = op;
    t.item_value = v;
    t.item_priority = p;
    pending_ops.push_back(t);
  endtask

  function automatic logic signed [31:0] extreme_word();
    case ($urandom_range(0, 3))
      0: return MIN_WORD;
      1: return MAX_WORD;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Mostly small values so key changes find matches and duplicates occur
  function automatic logic signed [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return $urandom;
    if (roll == 1) return extreme_word();
    return int'($urandom_range(0, 11)) - 6;
  endfunction

  // Narrow priorities force ties; wide ones exercise signed ordering
  function automatic logic signed [31:0] pick_prio();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll < 2) return int'($urandom_range(0, 6)) - 3;
    if (roll == 2) return extreme_word();
    return $urandom;
  endfunction

  task automatic build_stimulus();
    int kind;
    int n;
    int roll;
    // empty queue, unused codes, ties, signed extremes, key change corner cases
    add_item(OP_EXTRACT, 0, 0);
    add_item(OP_PEEK, 0, 0);
    add_item(OP_MODIFY, 0, 1);
    add_item(OP_SPARE_LO, -1, -1);
    add_item(OP_SPARE_HI, MIN_WORD, MAX_WORD);
    add_item(OP_INSERT, MIN_WORD, MAX_WORD);
    add_item(OP_INSERT, MAX_WORD, MIN_WORD);
    add_item(OP_INSERT, 0, MAX_WORD);
    add_item(OP_INSERT, -1, 0);
    add_item(OP_PEEK, 0, 0);
    add_item(OP_INCREASE, -1, 5);
    add_item(OP_INCREASE, -1, 3);
    add_item(OP_DECREASE, -1, 10);
    add_item(OP_DECREASE, -1, MIN_WORD);
    add_item(OP_MODIFY, 0, MIN_WORD);
    add_item(OP_INCREASE, 123, 9);
    add_item(OP_DECREASE, 123, 0);
    add_item(OP_PEEK, 0, 0);
    for (int i = 0; i < 5; i++) add_item(OP_EXTRACT, 0, 0);

    // random phases: fill runs, drain runs and mixed traffic
    n = pending_ops.size() + RANDOM_ITEMS;
    while (pending_ops.size() < n) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        roll = ($urandom_range(0, 3) == 0) ? DEPTH + 6 : $urandom_range(4, 20);
        for (int i = 0; i < roll; i++) add_item(OP_INSERT, pick_value(), pick_prio());
      end else if (kind == 1) begin
        roll = ($urandom_range(0, 3) == 0) ? DEPTH + 6 : $urandom_range(4, 20);
        for (int i = 0; i < roll; i++) add_item(OP_EXTRACT, pick_value(), pick_prio());
      end else begin
        for (int i = 0; i < 20; i++) begin
          roll = $urandom_range(0, 99);
          if (roll < 32) add_item(OP_INSERT, pick_value(), pick_prio());
          else if (roll < 52) add_item(OP_EXTRACT, pick_value(), pick_prio());
          else if (roll < 62) add_item(OP_PEEK, pick_value(), pick_prio());
          else if (roll < 72) add_item(OP_MODIFY, pick_value(), pick_prio());
          else if (roll < 82) add_item(OP_INCREASE, pick_value(), pick_prio());
          else if (roll < 92) add_item(OP_DECREASE, pick_value(), pick_prio());
          else if (roll < 96) add_item(OP_SPARE_LO, $urandom, $urandom);
          else add_item(OP_SPARE_HI, $urandom, $urandom);
        end
      end
    end
  endtask

  // Driver: offer transactions in bursts, predict on each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_queue_op(in_data));
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_data <= pending_ops.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted response with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left = 0;
      mode_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected response: result_value %0d status %0d entry_count %0d",
                 out_data.result_value, out_data.status, out_data.entry_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d", want.result_value,
                   out_data.result_value);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_data.entry_count);
            fail_count++;
          end
        end
        results_seen++;
        // hold off once for a long stretch so the input side backs up
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end

      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(50, 300);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_STEADY: out_ready <= 1'b1;
          RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Sequence the run: reset, wait for all responses, report
  initial begin
    build_stimulus();
    total_items = pending_ops.size();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (accepted_count < total_items) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_TIME);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/apq_pkg.sv
rtl/core/apq_ram.sv
rtl/core/apq_datapath.sv
rtl/core/apq_ctrl.sv
rtl/core/array_priority_queue.sv
test/tb_array_priority_queue.sv
